@@ sv/assert_macros.svh @@
// Assertion macros for the port-level checker file of the project.
// Depends on nothing; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define AST_CHK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define AST_CHK_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tmps_pkg.sv @@
// Shared types, codes and the canned pattern builder of the motion pattern sequencer.
// Depends on nothing; used by the top level, both checkers and the testbench.
`timescale 1ns / 1ps

package tmps_pkg;

   // item modes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   // motor commands
   localparam logic [2:0] CMD_HALT  = 3'd0;
   localparam logic [2:0] CMD_FWD   = 3'd1;
   localparam logic [2:0] CMD_BACK  = 3'd2;
   localparam logic [2:0] CMD_LEFT  = 3'd3;
   localparam logic [2:0] CMD_RIGHT = 3'd4;

   // pattern numbers
   localparam logic [3:0] PAT_NONE       = 4'd0;
   localparam logic [3:0] PAT_LEFT_RIGHT = 4'd1;
   localparam logic [3:0] PAT_FWD_BACK   = 4'd2;
   localparam logic [3:0] PAT_ZIGZAG     = 4'd3;
   localparam logic [3:0] PAT_SCAN       = 4'd4;
   localparam logic [3:0] PAT_SPIN       = 4'd5;
   localparam logic [3:0] PAT_PATROL     = 4'd6;
   localparam logic [3:0] PAT_DISAGREE   = 4'd7;
   localparam logic [3:0] PAT_HAPPY      = 4'd8;
   localparam logic [3:0] PAT_CURIOUS    = 4'd9;
   localparam logic [3:0] PAT_EXCITED    = 4'd10;
   localparam logic [3:0] PAT_SHY        = 4'd11;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 1'd1;

   localparam logic [15:0] DEAD_ZONE_RST   = 16'h0000;
   localparam logic [15:0] SPEED_LIMIT_RST = 16'hFFFF;

   // base step clamp
   localparam logic [15:0] STEP_MIN_MS = 16'd200;
   localparam logic [15:0] STEP_MAX_MS = 16'd5000;

   // fixed pauses
   localparam logic [13:0] DUR_P250 = 14'd250;
   localparam logic [13:0] DUR_P180 = 14'd180;
   localparam logic [13:0] DUR_P140 = 14'd140;
   localparam logic [13:0] DUR_P220 = 14'd220;
   localparam logic [13:0] DUR_P120 = 14'd120;

   // longest canned pattern, and default table depth
   localparam int PAT_STEPS     = 8;
   localparam int MAX_STEPS_DEF = 8;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         pattern;
      logic [15:0]        step_ms;
      logic signed [15:0] speed;
   } req_type;

   typedef struct packed {
      logic        running;
      logic [3:0]  active_pattern;
      logic [2:0]  motor_command;
      logic [15:0] drive_speed;
      logic [3:0]  step_number;
      logic [15:0] ms_since_start;
      logic [15:0] ms_to_go;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [13:0] dur;
   } step_type;

   typedef struct packed {
      logic                          known;
      logic [3:0]                    steps;
      logic [15:0]                   total;
      step_type [PAT_STEPS-1:0]      entry;
   } pattern_type;

   // Build the step list of pattern p from the clamped base step s.
   function automatic pattern_type build_pattern(logic [3:0] p, logic [15:0] s);
      pattern_type r;
      logic [13:0] sd;
      logic [13:0] hd;
      logic [13:0] dd;
      logic [15:0] h;
      r  = '0;
      sd = s[13:0];
      hd = s[14:1];
      dd = {s[12:0], 1'b0};
      h  = {1'b0, s[15:1]};
      r.known = 1'b1;
      case (p)
         PAT_LEFT_RIGHT, PAT_FWD_BACK: begin
            r.entry[0] = (p == PAT_LEFT_RIGHT) ? {CMD_LEFT, sd} : {CMD_FWD, sd};
            r.entry[1] = {CMD_HALT, DUR_P250};
            r.entry[2] = (p == PAT_LEFT_RIGHT) ? {CMD_RIGHT, sd} : {CMD_BACK, sd};
            r.entry[3] = {CMD_HALT, DUR_P250};
            r.steps = 4'd4;
            r.total = {s[14:0], 1'b0} + 16'd500;
         end
         PAT_ZIGZAG: begin
            r.entry[0] = {CMD_FWD, sd};
            r.entry[1] = {CMD_LEFT, hd};
            r.entry[2] = {CMD_FWD, sd};
            r.entry[3] = {CMD_RIGHT, hd};
            r.entry[4] = {CMD_FWD, sd};
            r.entry[5] = {CMD_HALT, DUR_P250};
            r.steps = 4'd6;
            r.total = {s[13:0], 2'b00} + 16'd250;
         end
         PAT_SCAN, PAT_CURIOUS: begin
            r.entry[0] = {CMD_LEFT, sd};
            r.entry[1] = {CMD_HALT, DUR_P180};
            r.entry[2] = {CMD_RIGHT, dd};
            r.entry[3] = {CMD_HALT, DUR_P180};
            r.entry[4] = {CMD_LEFT, sd};
            r.entry[5] = {CMD_HALT, DUR_P250};
            r.steps = 4'd6;
            r.total = {s[13:0], 2'b00} + 16'd610;
         end
         PAT_SPIN: begin
            r.entry[0] = {CMD_LEFT, hd};
            r.entry[1] = {CMD_RIGHT, hd};
            r.entry[2] = {CMD_LEFT, hd};
            r.entry[3] = {CMD_RIGHT, hd};
            r.entry[4] = {CMD_LEFT, hd};
            r.entry[5] = {CMD_HALT, DUR_P250};
            r.steps = 4'd6;
            r.total = {h[13:0], 2'b00} + h + 16'd250;
         end
         PAT_PATROL: begin
            r.entry[0] = {CMD_FWD, sd};
            r.entry[1] = {CMD_LEFT, hd};
            r.entry[2] = {CMD_FWD, sd};
            r.entry[3] = {CMD_RIGHT, hd};
            r.entry[4] = {CMD_BACK, hd};
            r.entry[5] = {CMD_HALT, DUR_P250};
            r.steps = 4'd6;
            r.total = {s[14:0], 1'b0} + {h[14:0], 1'b0} + h + 16'd250;
         end
         PAT_DISAGREE: begin
            r.entry[0] = {CMD_LEFT, sd};
            r.entry[1] = {CMD_HALT, DUR_P140};
            r.entry[2] = {CMD_RIGHT, sd};
            r.entry[3] = {CMD_HALT, DUR_P140};
            r.entry[4] = {CMD_LEFT, sd};
            r.entry[5] = {CMD_HALT, DUR_P140};
            r.entry[6] = {CMD_RIGHT, sd};
            r.entry[7] = {CMD_HALT, DUR_P220};
            r.steps = 4'd8;
            r.total = {s[13:0], 2'b00} + 16'd640;
         end
         PAT_HAPPY: begin
            r.entry[0] = {CMD_LEFT, sd};
            r.entry[1] = {CMD_HALT, DUR_P120};
            r.entry[2] = {CMD_LEFT, sd};
            r.entry[3] = {CMD_HALT, DUR_P120};
            r.entry[4] = {CMD_LEFT, sd};
            r.entry[5] = {CMD_HALT, DUR_P250};
            r.steps = 4'd6;
            r.total = {s[14:0], 1'b0} + s + 16'd490;
         end
         PAT_EXCITED: begin
            r.entry[0] = {CMD_FWD, sd};
            r.entry[1] = {CMD_LEFT, hd};
            r.entry[2] = {CMD_FWD, sd};
            r.entry[3] = {CMD_RIGHT, hd};
            r.entry[4] = {CMD_FWD, sd};
            r.entry[5] = {CMD_LEFT, hd};
            r.entry[6] = {CMD_HALT, DUR_P220};
            r.steps = 4'd7;
            r.total = {s[14:0], 1'b0} + s + {h[14:0], 1'b0} + h + 16'd220;
         end
         PAT_SHY: begin
            r.entry[0] = {CMD_BACK, sd};
            r.entry[1] = {CMD_HALT, DUR_P180};
            r.entry[2] = {CMD_RIGHT, hd};
            r.entry[3] = {CMD_HALT, DUR_P180};
            r.entry[4] = {CMD_FWD, hd};
            r.entry[5] = {CMD_HALT, DUR_P250};
            r.steps = 4'd6;
            r.total = s + {h[14:0], 1'b0} + 16'd610;
         end
         default: begin
            r.known = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

@@ sv/timed_motion_pattern_sequencer_top.sv @@
// Top level of the timed motion pattern sequencer: channels, step table and status.
// Depends on tmps_pkg.
`timescale 1ns / 1ps

// Use of the block
//  req channel: one beat per item (tick of one ms, start of a pattern, stop),
//    accepted at a clock edge with req_valid high and req_stall low.
//  rsp channel: exactly one status beat per request beat, in order, handed
//    over at an edge with rsp_valid high and rsp_stall low.
//  csr channel: dead zone (index 0) and speed limit (index 1); csr_ready is
//    always high, write only while no request beat is in flight.
//  An accepted request beat first sits in the input register; one pass of
//    logic then writes its status beat into the result register, from which
//    it is handed over. Throughput: one beat per cycle while the receiver
//    does not stall, set by that single pass of step table update, compare
//    and counter logic.
//  The step table is a short shift line: the current step always sits in
//    entry 0 and moves down one place whenever a step ends.
//  Reset (synchronous, active high): no pattern running, counters and held
//    speed zero, dead zone 0, speed limit 0xFFFF, both pipeline stages empty.
//    The step table is not cleared; only entries written by a start are read.
//  Receiver stall: the result beat holds; the input register still fills,
//    and req_stall rises only once both stages hold a beat.
module timed_motion_pattern_sequencer_top #(
   parameter int MAX_STEPS = tmps_pkg::MAX_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tmps_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tmps_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tmps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                      csr_wdata
);
   import tmps_pkg::*;

   // entries a start can fill
   localparam int FILL = (MAX_STEPS < PAT_STEPS) ? MAX_STEPS : PAT_STEPS;

   // pipeline registers
   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        out_valid_ff;
   rsp_type     out_data_ff;
   rsp_type     out_data_in;
   logic        advance;

   // configuration
   logic [15:0] dead_zone_ff;
   logic [15:0] speed_limit_ff;

   // sequencer state
   logic [3:0]  active_ff,     active_in;
   logic [3:0]  step_total_ff, step_total_in;
   logic [3:0]  cur_step_ff,   cur_step_in;
   logic [13:0] timer_ff,      timer_in;
   logic [15:0] elapsed_ff,    elapsed_in;
   logic [15:0] total_ff,      total_in;
   logic [15:0] held_speed_ff, held_speed_in;
   step_type    tab_ff [MAX_STEPS];
   step_type    tab_wr [MAX_STEPS];

   // working signals
   logic [15:0] step_clamped;
   pattern_type pat;
   logic [16:0] mag;
   logic [16:0] mag_lo;
   logic [15:0] speed_clamped;
   logic [13:0] timer_inc;
   logic        load;
   logic        shift;
   logic        halt;
   logic        live;
   logic [2:0]  cmd_sel;

   // advance the item when the result register is free or being emptied
   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (!out_valid_ff || !rsp_stall) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      // payload: take a fresh beat whenever the stage moves
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff   <= DEAD_ZONE_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEAD_ZONE:   dead_zone_ff   <= csr_wdata;
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // one pass over the item in the input register
   always_comb begin
      // clamp the base step and build the pattern
      if (in_data_ff.step_ms < STEP_MIN_MS) begin
         step_clamped = STEP_MIN_MS;
      end else if (in_data_ff.step_ms > STEP_MAX_MS) begin
         step_clamped = STEP_MAX_MS;
      end else begin
         step_clamped = in_data_ff.step_ms;
      end
      pat = build_pattern(in_data_ff.pattern, step_clamped);

      // magnitude, raised to the dead zone, then capped by the limit
      if (in_data_ff.speed[15]) begin
         mag = 17'h10000 - {1'b0, in_data_ff.speed};
      end else begin
         mag = {1'b0, in_data_ff.speed};
      end
      mag_lo = (mag < {1'b0, dead_zone_ff}) ? {1'b0, dead_zone_ff} : mag;
      speed_clamped = (mag_lo > {1'b0, speed_limit_ff}) ? speed_limit_ff : mag_lo[15:0];

      for (int i = 0; i < MAX_STEPS; i++) begin
         tab_wr[i] = '0;
      end
      for (int i = 0; i < FILL; i++) begin
         tab_wr[i] = pat.entry[i];
      end

      timer_inc = (timer_ff == 14'h3FFF) ? timer_ff : timer_ff + 14'd1;

      active_in     = active_ff;
      step_total_in = step_total_ff;
      cur_step_in   = cur_step_ff;
      timer_in      = timer_ff;
      elapsed_in    = elapsed_ff;
      total_in      = total_ff;
      held_speed_in = held_speed_ff;
      load  = 1'b0;
      shift = 1'b0;
      halt  = 1'b0;

      if (advance) begin
         case (in_data_ff.mode)
            MODE_START: begin
               // an unknown pattern only reports the status
               if (pat.known) begin
                  load          = 1'b1;
                  active_in     = in_data_ff.pattern;
                  step_total_in = pat.steps;
                  total_in      = pat.total;
                  held_speed_in = speed_clamped;
                  cur_step_in   = 4'd0;
                  timer_in      = 14'd0;
                  elapsed_in    = 16'd0;
               end
            end
            MODE_STOP: begin
               halt = 1'b1;
            end
            MODE_TICK: begin
               if (active_ff != PAT_NONE) begin
                  if (cur_step_ff >= step_total_ff) begin
                     halt = 1'b1;
                  end else begin
                     elapsed_in = (elapsed_ff == 16'hFFFF) ? elapsed_ff
                                                           : elapsed_ff + 16'd1;
                     // step time used up: move to the next step
                     if (timer_inc >= tab_ff[0].dur) begin
                        shift       = 1'b1;
                        cur_step_in = cur_step_ff + 4'd1;
                        timer_in    = 14'd0;
                        if (cur_step_ff + 4'd1 >= step_total_ff) begin
                           halt = 1'b1;
                        end
                     end else begin
                        timer_in = timer_inc;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (halt) begin
         active_in     = PAT_NONE;
         cur_step_in   = 4'd0;
         step_total_in = 4'd0;
         total_in      = 16'd0;
         timer_in      = 14'd0;
         elapsed_in    = 16'd0;
      end

      // status from the state after this item
      if (load) begin
         cmd_sel = pat.entry[0].cmd;
      end else if (shift) begin
         cmd_sel = tab_ff[1].cmd;
      end else begin
         cmd_sel = tab_ff[0].cmd;
      end

      live = (active_in != PAT_NONE);
      out_data_in.running        = live;
      out_data_in.active_pattern = active_in;
      out_data_in.drive_speed    = held_speed_in;
      out_data_in.step_number    = cur_step_in;
      out_data_in.ms_since_start = live ? elapsed_in : 16'd0;
      out_data_in.motor_command  = CMD_HALT;
      out_data_in.ms_to_go       = 16'd0;
      if (live && (cur_step_in < step_total_in)) begin
         out_data_in.motor_command = cmd_sel;
         out_data_in.ms_to_go      = (elapsed_in >= total_in) ? 16'd0
                                                              : total_in - elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= PAT_NONE;
         step_total_ff <= 4'd0;
         cur_step_ff   <= 4'd0;
         timer_ff      <= 14'd0;
         elapsed_ff    <= 16'd0;
         total_ff      <= 16'd0;
         held_speed_ff <= 16'd0;
      end else begin
         active_ff     <= active_in;
         step_total_ff <= step_total_in;
         cur_step_ff   <= cur_step_in;
         timer_ff      <= timer_in;
         elapsed_ff    <= elapsed_in;
         total_ff      <= total_in;
         held_speed_ff <= held_speed_in;
      end
   end

   // step table: load on start, drop the finished step when a step ends
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_STEPS; i++) begin
            tab_ff[i] <= tab_wr[i];
         end
      end else if (shift) begin
         for (int i = 0; i < MAX_STEPS - 1; i++) begin
            tab_ff[i] <= tab_ff[i+1];
         end
      end
   end

endmodule

@@ sv/tmps_checker.sv @@
// Port-level checks for the motion pattern sequencer, bound to its top level.
// Depends on tmps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmps_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tmps_pkg::rsp_type rsp_data
);
   import tmps_pkg::*;

   logic idle_clear;

   assign idle_clear = (rsp_data.motor_command == CMD_HALT) && (rsp_data.step_number == 4'd0) &&
                       (rsp_data.ms_since_start == 16'd0) && (rsp_data.ms_to_go == 16'd0);

   // hold a stalled result beat
   `AST_CHK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result beat changed under stall")

   // idle status carries no command and zero counters
   `AST_CHK(a_idle_zero, clock, reset, rsp_valid && !rsp_data.running |-> idle_clear, "idle status not cleared")

   // running flag tracks the pattern number
   `AST_CHK(a_run_pat, clock, reset, rsp_valid |-> rsp_data.running == (rsp_data.active_pattern != PAT_NONE), "running flag disagrees with pattern")

   // no result beat is valid right after reset
   `AST_CHK_NR(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind timed_motion_pattern_sequencer_top tmps_checker u_tmps_checker (.*);

@@ sim/tmps_status_checker.sv @@
// Status checker for the timed motion pattern sequencer: watches the request, result and
// register channels, predicts every status beat and compares it field by field.
// Depends on tmps_pkg.
`timescale 1ns / 1ps

module tmps_status_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  tmps_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tmps_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [tmps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import tmps_pkg::*;

   // register copies
   logic [15:0] dead_zone;
   logic [15:0] speed_limit;

   // sequencer state as predicted
   logic [3:0]  cur_pat;
   logic [2:0]  plan_cmd [MAX_STEPS_DEF];
   logic [13:0] plan_dur [MAX_STEPS_DEF];
   logic [3:0]  plan_len;
   logic [3:0]  step_idx;
   logic [13:0] step_cnt;
   logic [15:0] run_ms;
   logic [15:0] plan_total;
   logic [15:0] held_speed;

   rsp_type due_status [$];
   int      errors  = 0;
   int      waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   function automatic void halt_plan();
      cur_pat    = PAT_NONE;
      step_idx   = 4'd0;
      plan_len   = 4'd0;
      plan_total = 16'd0;
      step_cnt   = 14'd0;
      run_ms     = 16'd0;
   endfunction

   function automatic void set_step(int i, logic [2:0] c, int d);
      plan_cmd[i] = c;
      plan_dur[i] = 14'(d);
   endfunction

   // Fill the step list for pattern p from the clamped base step s; 0 if p is unknown.
   function automatic bit load_plan(logic [3:0] p, int s);
      int h;
      int tot;
      h   = s / 2;
      tot = 0;
      case (p)
         PAT_LEFT_RIGHT: begin
            set_step(0, CMD_LEFT, s);  set_step(1, CMD_HALT, DUR_P250);
            set_step(2, CMD_RIGHT, s); set_step(3, CMD_HALT, DUR_P250);
            plan_len = 4'd4; tot = 2 * s + 500;
         end
         PAT_FWD_BACK: begin
            set_step(0, CMD_FWD, s);  set_step(1, CMD_HALT, DUR_P250);
            set_step(2, CMD_BACK, s); set_step(3, CMD_HALT, DUR_P250);
            plan_len = 4'd4; tot = 2 * s + 500;
         end
         PAT_ZIGZAG: begin
            set_step(0, CMD_FWD, s); set_step(1, CMD_LEFT, h);
            set_step(2, CMD_FWD, s); set_step(3, CMD_RIGHT, h);
            set_step(4, CMD_FWD, s); set_step(5, CMD_HALT, DUR_P250);
            plan_len = 4'd6; tot = 4 * s + 250;
         end
         PAT_SCAN, PAT_CURIOUS: begin
            set_step(0, CMD_LEFT, s);      set_step(1, CMD_HALT, DUR_P180);
            set_step(2, CMD_RIGHT, 2 * s); set_step(3, CMD_HALT, DUR_P180);
            set_step(4, CMD_LEFT, s);      set_step(5, CMD_HALT, DUR_P250);
            plan_len = 4'd6; tot = 4 * s + 610;
         end
         PAT_SPIN: begin
            set_step(0, CMD_LEFT, h);  set_step(1, CMD_RIGHT, h);
            set_step(2, CMD_LEFT, h);  set_step(3, CMD_RIGHT, h);
            set_step(4, CMD_LEFT, h);  set_step(5, CMD_HALT, DUR_P250);
            plan_len = 4'd6; tot = 5 * h + 250;
         end
         PAT_PATROL: begin
            set_step(0, CMD_FWD, s);  set_step(1, CMD_LEFT, h);
            set_step(2, CMD_FWD, s);  set_step(3, CMD_RIGHT, h);
            set_step(4, CMD_BACK, h); set_step(5, CMD_HALT, DUR_P250);
            plan_len = 4'd6; tot = 2 * s + 3 * h + 250;
         end
         PAT_DISAGREE: begin
            set_step(0, CMD_LEFT, s);  set_step(1, CMD_HALT, DUR_P140);
            set_step(2, CMD_RIGHT, s); set_step(3, CMD_HALT, DUR_P140);
            set_step(4, CMD_LEFT, s);  set_step(5, CMD_HALT, DUR_P140);
            set_step(6, CMD_RIGHT, s); set_step(7, CMD_HALT, DUR_P220);
            plan_len = 4'd8; tot = 4 * s + 640;
         end
         PAT_HAPPY: begin
            set_step(0, CMD_LEFT, s); set_step(1, CMD_HALT, DUR_P120);
            set_step(2, CMD_LEFT, s); set_step(3, CMD_HALT, DUR_P120);
            set_step(4, CMD_LEFT, s); set_step(5, CMD_HALT, DUR_P250);
            plan_len = 4'd6; tot = 3 * s + 490;
         end
         PAT_EXCITED: begin
            set_step(0, CMD_FWD, s);  set_step(1, CMD_LEFT, h);
            set_step(2, CMD_FWD, s);  set_step(3, CMD_RIGHT, h);
            set_step(4, CMD_FWD, s);  set_step(5, CMD_LEFT, h);
            set_step(6, CMD_HALT, DUR_P220);
            plan_len = 4'd7; tot = 3 * s + 3 * h + 220;
         end
         PAT_SHY: begin
            set_step(0, CMD_BACK, s);  set_step(1, CMD_HALT, DUR_P180);
            set_step(2, CMD_RIGHT, h); set_step(3, CMD_HALT, DUR_P180);
            set_step(4, CMD_FWD, h);   set_step(5, CMD_HALT, DUR_P250);
            plan_len = 4'd6; tot = s + 2 * h + 610;
         end
         default: return 1'b0;
      endcase
      plan_total = 16'(tot);
      return 1'b1;
   endfunction

   function automatic bit step_live();
      return (int'(step_idx) < int'(plan_len)) && (int'(step_idx) < MAX_STEPS_DEF);
   endfunction

   // Apply one request beat to the predicted state and return the status it answers with.
   function automatic rsp_type predict_status(req_type beat);
      rsp_type     r;
      logic [15:0] base;
      logic [15:0] raw;
      logic [16:0] mag;
      case (beat.mode)
         MODE_START: begin
            base = beat.step_ms;
            if (base < STEP_MIN_MS)      base = STEP_MIN_MS;
            else if (base > STEP_MAX_MS) base = STEP_MAX_MS;
            if (load_plan(beat.pattern, int'(base))) begin
               raw = beat.speed;
               mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
               if (mag < {1'b0, dead_zone})   mag = {1'b0, dead_zone};
               if (mag > {1'b0, speed_limit}) mag = {1'b0, speed_limit};
               held_speed = mag[15:0];
               cur_pat    = beat.pattern;
               step_idx   = 4'd0;
               step_cnt   = 14'd0;
               run_ms     = 16'd0;
            end
         end
         MODE_STOP: halt_plan();
         MODE_TICK: begin
            if (cur_pat != PAT_NONE) begin
               if (!step_live()) begin
                  halt_plan();
               end else begin
                  if (step_cnt < 14'h3FFF) step_cnt = step_cnt + 14'd1;
                  if (run_ms < 16'hFFFF)   run_ms = run_ms + 16'd1;
                  if (step_cnt >= plan_dur[int'(step_idx)]) begin
                     step_idx = step_idx + 4'd1;
                     step_cnt = 14'd0;
                     if (step_idx >= plan_len) halt_plan();
                  end
               end
            end
         end
         default: ;
      endcase

      r                = '0;
      r.active_pattern = cur_pat;
      r.drive_speed    = held_speed;
      r.step_number    = step_idx;
      if (cur_pat != PAT_NONE) begin
         r.running        = 1'b1;
         r.ms_since_start = run_ms;
         if (step_live()) begin
            r.motor_command = plan_cmd[int'(step_idx)];
            r.ms_to_go      = (run_ms >= plan_total) ? 16'd0 : plan_total - run_ms;
         end
      end
      return r;
   endfunction

   task automatic match_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         dead_zone   = DEAD_ZONE_RST;
         speed_limit = SPEED_LIMIT_RST;
         held_speed  = 16'd0;
         halt_plan();
         due_status.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEAD_ZONE:   dead_zone = csr_wdata;
               CSR_SPEED_LIMIT: speed_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_status.size() == 0) begin
               $error("status beat with no request beat waiting");
               errors++;
            end else begin
               want = due_status.pop_front();
               match_field("running", 16'(want.running), 16'(rsp_data.running));
               match_field("active_pattern", 16'(want.active_pattern),
                           16'(rsp_data.active_pattern));
               match_field("motor_command", 16'(want.motor_command),
                           16'(rsp_data.motor_command));
               match_field("drive_speed", want.drive_speed, rsp_data.drive_speed);
               match_field("step_number", 16'(want.step_number), 16'(rsp_data.step_number));
               match_field("ms_since_start", want.ms_since_start, rsp_data.ms_since_start);
               match_field("ms_to_go", want.ms_to_go, rsp_data.ms_to_go);
            end
         end
         if (req_valid && !req_stall) due_status.push_back(predict_status(req_data));
      end
      waiting = due_status.size();
   end

endmodule

@@ sim/timed_motion_pattern_sequencer_top_tb.sv @@
// Testbench top for the timed motion pattern sequencer: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on tmps_pkg, the top level and tmps_status_checker.
`timescale 1ns / 1ps

module timed_motion_pattern_sequencer_top_tb;
   import tmps_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam logic [3:0] PAT_TOP_CODE  = 4'd15;

   localparam int HOLD_OFF_CYCLES = 80;    // long receiver hold-off
   localparam int DRAIN_CYCLES    = 4;     // two-stage latency plus margin
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any accepted beat
   localparam int MIX_BEATS       = 40;    // least number of random beats per register setting

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   int fail_count;
   int pending;
   int beats_sent   = 0;
   int burst_left   = 0;
   int quiet_cycles = 0;
   bit hold_off_req = 1'b0;

   timed_motion_pattern_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tmps_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic req_type make_beat(logic [1:0] m, logic [3:0] p, logic [15:0] ms,
                                         logic [15:0] spd);
      req_type b;
      b.mode    = m;
      b.pattern = p;
      b.step_ms = ms;
      b.speed   = spd;
      return b;
   endfunction

   // Ticks and stops carry random don't-care fields so every payload bit toggles.
   function automatic req_type tick_beat();
      return make_beat(MODE_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   function automatic req_type stop_beat();
      return make_beat(MODE_STOP, 4'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   // Mostly short base steps, so steps end within a few hundred ticks.
   function automatic logic [15:0] pick_step_ms();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)      return 16'($urandom_range(0, 200));
      else if (sel < 8) return 16'($urandom_range(201, 700));
      else if (sel < 9) return 16'($urandom_range(4990, 5010));
      else              return 16'($urandom);
   endfunction

   // Offer one beat and hold it until accepted; then maybe open a gap before the next.
   task automatic send_beat(input req_type beat);
      int gap;
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      // keep offering without gaps while the receiver is holding off
      if (!hold_off_req) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Drop valid, wait for every status beat to come back, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic: mostly a start followed by a run of ticks, the rest noise,
   // unknown patterns and stray stops or ticks. One receiver hold-off per call.
   task automatic run_mix(input int budget);
      int goal;
      int squeeze_at;
      int ticks;
      int sel;
      logic [3:0] odd_pat;
      goal       = beats_sent + budget;
      squeeze_at = beats_sent + int'($urandom_range(0, budget / 2));
      while (beats_sent < goal) begin
         if (squeeze_at >= 0 && beats_sent >= squeeze_at) begin
            hold_off_req = 1'b1;
            squeeze_at   = -1;
         end
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            send_beat(make_beat(MODE_START, 4'($urandom_range(1, 11)), pick_step_ms(),
                                16'($urandom)));
            ticks = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 60)
                                               : $urandom_range(100, 450);
            repeat (ticks) send_beat(tick_beat());
            if ($urandom_range(0, 3) == 0) send_beat(stop_beat());
         end else if (sel < 80) begin
            send_beat(make_beat(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom)));
         end else if (sel < 90) begin
            odd_pat = 4'($urandom_range(11, 15));
            if (odd_pat == PAT_SHY) odd_pat = PAT_NONE;
            send_beat(make_beat(MODE_START, odd_pat, pick_step_ms(), 16'($urandom)));
         end else if (sel < 95) begin
            send_beat(stop_beat());
         end else begin
            send_beat(tick_beat());
         end
      end
   endtask

   // Receiver: stretches of random length, each with its own stall density,
   // broken off by a long hold-off whenever the stimulus asks for one.
   initial begin : receiver_stalls
      int left;
      int pct;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            repeat (HOLD_OFF_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_off_req = 1'b0;
         end else begin
            left = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
               0:       pct = 0;
               1:       pct = 20;
               2:       pct = 50;
               default: pct = 85;
            endcase
            while (left > 0 && !hold_off_req) begin
               rsp_stall <= ($urandom_range(0, 99) < pct);
               @(posedge clock);
               left--;
            end
         end
      end
   end

   // Watchdog: end the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DEAD_ZONE;
      csr_wdata = 16'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats with reset register values: idle cases first
      send_beat(tick_beat());                                              // tick while idle
      send_beat(stop_beat());                                              // stop while idle
      send_beat(make_beat(MODE_UNUSED, PAT_SPIN, 16'd1000, 16'h0100));     // unused mode
      send_beat(make_beat(MODE_START, PAT_NONE, 16'd1000, 16'h0100));      // unknown pattern
      send_beat(make_beat(MODE_START, PAT_TOP_CODE, 16'd1000, 16'h0100));  // unknown pattern
      // negative full scale speed, base step clamped up from zero
      send_beat(make_beat(MODE_START, PAT_LEFT_RIGHT, 16'd0, 16'h8000));
      send_beat(tick_beat());
      send_beat(tick_beat());
      // replace the running pattern, base step clamped down from the top
      send_beat(make_beat(MODE_START, PAT_FWD_BACK, 16'hFFFF, 16'h7FFF));
      send_beat(tick_beat());
      // every remaining pattern, around both clamp edges and with alternating bits
      send_beat(make_beat(MODE_START, PAT_ZIGZAG, 16'd199, 16'h0000));
      send_beat(make_beat(MODE_START, PAT_SCAN, 16'd200, 16'hFFFF));
      send_beat(make_beat(MODE_START, PAT_SPIN, 16'd201, 16'h0001));
      send_beat(make_beat(MODE_START, PAT_PATROL, 16'd4999, 16'h8001));
      send_beat(make_beat(MODE_START, PAT_DISAGREE, 16'd5000, 16'h0100));
      send_beat(make_beat(MODE_START, PAT_HAPPY, 16'd5001, 16'hFF00));
      send_beat(make_beat(MODE_START, PAT_CURIOUS, 16'h5555, 16'hAAAA));
      send_beat(make_beat(MODE_START, PAT_EXCITED, 16'hAAAA, 16'h5555));
      send_beat(make_beat(MODE_START, PAT_SHY, 16'd300, 16'h1234));
      send_beat(tick_beat());
      send_beat(stop_beat());                                              // stop while running
      send_beat(tick_beat());
      drain();

      // Narrow window well inside the speed range
      write_reg(CSR_DEAD_ZONE, 16'h0080);
      write_reg(CSR_SPEED_LIMIT, 16'h7000);
      run_mix(MIX_BEATS);
      drain();

      // Limit below dead zone: the limit must win
      write_reg(CSR_DEAD_ZONE, 16'hFFFF);
      write_reg(CSR_SPEED_LIMIT, 16'h0000);
      run_mix(MIX_BEATS);
      drain();

      // Widest window, then one spin burst run through to its natural end
      write_reg(CSR_DEAD_ZONE, 16'h0000);
      write_reg(CSR_SPEED_LIMIT, 16'hFFFF);
      run_mix(MIX_BEATS);
      send_beat(make_beat(MODE_START, PAT_SPIN, 16'd0, 16'($urandom)));
      repeat (760) send_beat(tick_beat());
      drain();

      // Random bounds, limit written first
      write_reg(CSR_SPEED_LIMIT, 16'($urandom));
      write_reg(CSR_DEAD_ZONE, 16'($urandom));
      run_mix(MIX_BEATS);
      drain();

      // Equal bounds at mid scale: every start of a known pattern pins the speed
      write_reg(CSR_DEAD_ZONE, 16'h8000);
      write_reg(CSR_SPEED_LIMIT, 16'h8000);
      run_mix(MIX_BEATS);
      drain();

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/tmps_pkg.sv
sv/timed_motion_pattern_sequencer_top.sv
sv/tmps_checker.sv
sim/tmps_status_checker.sv
sim/timed_motion_pattern_sequencer_top_tb.sv
